// ----- rtl/ssce_pkg.sv -----
// Package: shared constants, types and helpers for the sparse convolution engine.
package ssce_pkg;

    localparam int INPUT_DEPTH  = 16384;
    localparam int MAX_NONZEROS = 256;
    localparam int OUTPUT_DEPTH = 4096;
    localparam int FRAC_BITS    = 5;

    localparam int IN_AW  = $clog2(INPUT_DEPTH);
    localparam int NZ_AW  = $clog2(MAX_NONZEROS);
    localparam int NZ_CW  = $clog2(MAX_NONZEROS + 1);
    localparam int OUT_AW = $clog2(OUTPUT_DEPTH);
    localparam int OUT_CW = $clog2(OUTPUT_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_APPEND  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_STRIDE_Y    = 3'd0,
        REG_STRIDE_X    = 3'd1,
        REG_OUT_ROWS    = 3'd2,
        REG_OUT_COLS    = 3'd3,
        REG_IN_ROWS     = 3'd4,
        REG_IN_COLS     = 3'd5,
        REG_FILTER_ROWS = 3'd6,
        REG_FILTER_COLS = 3'd7
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DEC_LAY,
        ST_DEC_ROW,
        ST_PIX,
        ST_TAP,
        ST_MUL,
        ST_ACC,
        ST_WRITE,
        ST_READ_WAIT,
        ST_OUT
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
        if (v > 33'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -33'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// ----- rtl/ssce_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ssce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/sparse_strided_conv_engine.sv -----
// Top level: sparse-weight strided 2-D convolution engine.
// Loads and appends leave the engine idle, so words stream in at one a cycle
// while the output register is free. A read fetches its word from the output
// memory in the read-wait state and registers it onto the output. A compute
// walks every output pixel and, for each, every stored nonzero through a shared
// multiply/accumulate path: bit-serial layer divide of the filter index, row and
// column decode, tap address, input read, multiply, accumulate; then a write-back
// per pixel (an empty filter skips the per-nonzero steps); the done word follows
// once the output register is free. After reset a clearing pass writes zero to
// all OUTPUT_DEPTH output entries, one a cycle, before the first word is accepted.
module sparse_strided_conv_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // fields from bit 0: address[13:0], value[29:14], offset[41:30], zero pad
    input  logic [47:0] s_axis_tdata,
    // fields from bit 0: opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fields from bit 0: result_value[15:0]
    output logic [15:0] m_axis_tdata,
    // fields from bit 0: done_res[0]
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IN_AW  = ssce_pkg::IN_AW;
    localparam int NZ_AW  = ssce_pkg::NZ_AW;
    localparam int NZ_CW  = ssce_pkg::NZ_CW;
    localparam int OUT_AW = ssce_pkg::OUT_AW;
    localparam int OUT_CW = ssce_pkg::OUT_CW;

    // configuration
    logic [3:0] r_stride_y, r_stride_x, r_filter_rows, r_filter_cols;
    logic [6:0] r_out_rows, r_out_cols;
    logic [7:0] r_in_rows, r_in_cols;
    logic       cfg_we;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_y    <= 4'd1;
            r_stride_x    <= 4'd1;
            r_out_rows    <= 7'd1;
            r_out_cols    <= 7'd1;
            r_in_rows     <= 8'd1;
            r_in_cols     <= 8'd1;
            r_filter_rows <= 4'd1;
            r_filter_cols <= 4'd1;
        end else if (cfg_we) begin
            unique case (ssce_pkg::t_reg_index'(cfg_idx))
                ssce_pkg::REG_STRIDE_Y:    r_stride_y    <= pwdata[3:0];
                ssce_pkg::REG_STRIDE_X:    r_stride_x    <= pwdata[3:0];
                ssce_pkg::REG_OUT_ROWS:    r_out_rows    <= pwdata[6:0];
                ssce_pkg::REG_OUT_COLS:    r_out_cols    <= pwdata[6:0];
                ssce_pkg::REG_IN_ROWS:     r_in_rows     <= pwdata[7:0];
                ssce_pkg::REG_IN_COLS:     r_in_cols     <= pwdata[7:0];
                ssce_pkg::REG_FILTER_ROWS: r_filter_rows <= pwdata[3:0];
                ssce_pkg::REG_FILTER_COLS: r_filter_cols <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ssce_pkg::t_reg_index'(cfg_idx))
            ssce_pkg::REG_STRIDE_Y:    prdata = {28'd0, r_stride_y};
            ssce_pkg::REG_STRIDE_X:    prdata = {28'd0, r_stride_x};
            ssce_pkg::REG_OUT_ROWS:    prdata = {25'd0, r_out_rows};
            ssce_pkg::REG_OUT_COLS:    prdata = {25'd0, r_out_cols};
            ssce_pkg::REG_IN_ROWS:     prdata = {24'd0, r_in_rows};
            ssce_pkg::REG_IN_COLS:     prdata = {24'd0, r_in_cols};
            ssce_pkg::REG_FILTER_ROWS: prdata = {28'd0, r_filter_rows};
            ssce_pkg::REG_FILTER_COLS: prdata = {28'd0, r_filter_cols};
            default:                   prdata = 32'd0;
        endcase
    end

    // input word fields
    logic [13:0]        in_addr;
    logic signed [15:0] in_value;
    logic [11:0]        in_offset;
    logic               in_acc;

    assign in_addr   = s_axis_tdata[13:0];
    assign in_value  = s_axis_tdata[29:14];
    assign in_offset = s_axis_tdata[41:30];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    ssce_pkg::t_state r_state, n_state;

    logic [11:0]        r_run_idx, n_run_idx;
    logic [NZ_CW-1:0]   r_nz_cnt, n_nz_cnt;
    logic [OUT_CW-1:0]  r_clr, n_clr;
    logic [NZ_AW-1:0]   r_p, n_p;
    logic [6:0]         r_row, n_row, r_col, n_col;
    logic [11:0]        r_oi, n_oi;
    logic [11:0]        r_rem, n_rem;
    logic [11:0]        r_lay, n_lay;
    logic [3:0]         r_dstep, n_dstep;
    logic [19:0]        r_base, n_base;
    logic [11:0]        r_y, n_y, r_x, n_x;
    logic [28:0]        r_flat, n_flat;
    logic               r_tap_ok, n_tap_ok;
    logic signed [31:0] r_prod, n_prod;
    logic signed [15:0] r_acc, n_acc;
    logic               r_ovalid, n_ovalid;
    logic [15:0]        r_odata, n_odata;
    logic               r_odone, n_odone;
    logic               r_rd_ok, n_rd_ok;

    // memory ports
    logic               in_we, w_we, o_we;
    logic [IN_AW-1:0]   in_waddr, in_raddr;
    logic [15:0]        in_rdata, w_rdata, o_rdata, o_wdata;
    logic [11:0]        wi_rdata;
    logic [NZ_AW-1:0]   w_waddr, w_raddr;
    logic [OUT_AW-1:0]  o_waddr, o_raddr;

    ssce_ram #(.WIDTH(16), .DEPTH(ssce_pkg::INPUT_DEPTH)) u_input_ram (
        .i_clk(i_clk), .i_we(in_we), .i_waddr(in_waddr), .i_wdata(in_value),
        .i_raddr(in_raddr), .o_rdata(in_rdata)
    );
    ssce_ram #(.WIDTH(16), .DEPTH(ssce_pkg::MAX_NONZEROS)) u_weight_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(in_value),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    ssce_ram #(.WIDTH(12), .DEPTH(ssce_pkg::MAX_NONZEROS)) u_index_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(n_run_idx),
        .i_raddr(w_raddr), .o_rdata(wi_rdata)
    );
    ssce_ram #(.WIDTH(16), .DEPTH(ssce_pkg::OUTPUT_DEPTH)) u_output_ram (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    logic [3:0]  fr, fc;
    logic [7:0]  plane;
    logic        out_free;
    logic signed [15:0] tap_val;
    logic signed [32:0] sum;
    logic signed [31:0] shifted;
    logic        last_p, last_col;
    logic [11:0] div_trial;
    logic [3:0]  dec_fy;

    assign fr       = (r_filter_rows == 4'd0) ? 4'd1 : r_filter_rows;
    assign fc       = (r_filter_cols == 4'd0) ? 4'd1 : r_filter_cols;
    assign plane    = fr * fc;
    assign out_free = !r_ovalid || m_axis_tready;
    assign tap_val  = r_tap_ok ? in_rdata : 16'sd0;
    assign shifted  = r_prod >>> ssce_pkg::FRAC_BITS;
    assign last_p   = ({1'b0, r_p} == NZ_CW'(r_nz_cnt - 1'b1)) || (r_nz_cnt == '0);
    assign last_col = (r_col == r_out_cols - 7'd1);
    assign sum      = (r_p == '0) ? 33'(ssce_pkg::sat16(33'(shifted)))
                    : 33'(r_acc) + 33'(ssce_pkg::sat16(33'(shifted)));

    assign s_axis_tready = (r_state == ssce_pkg::ST_IDLE) && out_free;

    always_comb begin
        n_state  = r_state;
        n_run_idx = r_run_idx;
        n_nz_cnt = r_nz_cnt;
        n_clr    = r_clr;
        n_p      = r_p;
        n_row    = r_row;
        n_col    = r_col;
        n_oi     = r_oi;
        n_rem    = r_rem;
        n_lay    = r_lay;
        n_dstep  = r_dstep;
        n_base   = r_base;
        n_y      = r_y;
        n_x      = r_x;
        n_flat   = r_flat;
        n_tap_ok = r_tap_ok;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_rd_ok  = r_rd_ok;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_odone  = r_odone;
        div_trial = 12'd0;
        dec_fy   = 4'd0;
        in_we    = 1'b0;
        in_waddr = in_addr[IN_AW-1:0];
        in_raddr = r_flat[IN_AW-1:0];
        w_we     = 1'b0;
        w_waddr  = r_nz_cnt[NZ_AW-1:0];
        w_raddr  = r_p;
        o_we     = 1'b0;
        o_waddr  = r_oi[OUT_AW-1:0];
        o_wdata  = r_acc;
        o_raddr  = in_addr[OUT_AW-1:0];
        unique case (r_state)
            ssce_pkg::ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr[OUT_AW-1:0];
                o_wdata = 16'd0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == OUT_CW'(ssce_pkg::OUTPUT_DEPTH - 1)) begin
                    n_state = ssce_pkg::ST_IDLE;
                end
            end
            ssce_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (ssce_pkg::t_opcode'(s_axis_tuser))
                        ssce_pkg::OP_LOAD: begin
                            in_we = 32'(in_addr) < ssce_pkg::INPUT_DEPTH;
                        end
                        ssce_pkg::OP_APPEND: begin
                            if (r_nz_cnt < NZ_CW'(ssce_pkg::MAX_NONZEROS)) begin
                                n_run_idx = r_run_idx + in_offset;
                                w_we      = 1'b1;
                                n_nz_cnt  = r_nz_cnt + 1'b1;
                            end
                        end
                        ssce_pkg::OP_COMPUTE: begin
                            n_row   = 7'd0;
                            n_col   = 7'd0;
                            n_oi    = 12'd0;
                            n_p     = '0;
                            n_state = (r_out_rows == 7'd0 || r_out_cols == 7'd0)
                                    ? ssce_pkg::ST_OUT : ssce_pkg::ST_PIX;
                            if (r_nz_cnt == '0) begin
                                n_acc = 16'sd0;
                            end
                        end
                        ssce_pkg::OP_READ: begin
                            n_rd_ok = 32'(in_addr) < ssce_pkg::OUTPUT_DEPTH;
                            n_state = ssce_pkg::ST_READ_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ssce_pkg::ST_READ_WAIT: begin
                n_ovalid = 1'b1;
                n_odata  = r_rd_ok ? o_rdata : 16'd0;
                n_odone  = 1'b0;
                n_state  = ssce_pkg::ST_IDLE;
            end
            ssce_pkg::ST_PIX: begin
                // index memory read issued for r_p; skip when the filter is empty
                n_rem   = 12'd0;
                n_lay   = 12'd0;
                n_dstep = 4'd11;
                n_state = (r_nz_cnt == '0) ? ssce_pkg::ST_WRITE : ssce_pkg::ST_DEC_LAY;
            end
            ssce_pkg::ST_DEC_LAY: begin
                // one restoring divide step a cycle, most significant index bit first
                div_trial = {r_rem[10:0], wi_rdata[r_dstep]};
                if (div_trial >= 12'(plane)) begin
                    n_rem = div_trial - 12'(plane);
                    n_lay = {r_lay[10:0], 1'b1};
                end else begin
                    n_rem = div_trial;
                    n_lay = {r_lay[10:0], 1'b0};
                end
                n_dstep = r_dstep - 4'd1;
                if (r_dstep == 4'd0) begin
                    n_state = ssce_pkg::ST_DEC_ROW;
                end
            end
            ssce_pkg::ST_DEC_ROW: begin
                dec_fy = 4'd0;
                n_x    = 12'(r_rem);
                for (int k = 14; k >= 1; k--) begin
                    if (dec_fy == 4'd0 && r_rem >= 12'(fc) * 12'(k)) begin
                        dec_fy = 4'(k);
                        n_x    = r_rem - 12'(fc) * 12'(k);
                    end
                end
                n_y     = 12'(r_row) * 12'(r_stride_y) + 12'(dec_fy);
                n_x     = 12'(r_col) * 12'(r_stride_x) + n_x;
                n_base  = 20'(r_lay) * 20'(r_in_rows);
                n_state = ssce_pkg::ST_TAP;
            end
            ssce_pkg::ST_TAP: begin
                n_tap_ok = (r_y < 12'(r_in_rows)) && (r_x < 12'(r_in_cols));
                n_flat   = (29'(r_base) + 29'(r_y)) * 29'(r_in_cols) + 29'(r_x);
                n_state  = ssce_pkg::ST_MUL;
            end
            ssce_pkg::ST_MUL: begin
                // input read of r_flat issued here; weight read of r_p is stable
                n_tap_ok = r_tap_ok && (32'(r_flat) < ssce_pkg::INPUT_DEPTH);
                n_state  = ssce_pkg::ST_ACC;
            end
            ssce_pkg::ST_ACC: begin
                n_prod = r_tap_ok ? 32'(signed'(w_rdata)) * 32'(tap_val) : 32'sd0;
                n_state = ssce_pkg::ST_WRITE;
                n_p     = r_p;
            end
            ssce_pkg::ST_WRITE: begin
                if (r_nz_cnt != '0) begin
                    n_acc = ssce_pkg::sat16(sum);
                end
                if (!last_p) begin
                    n_p     = r_p + 1'b1;
                    n_state = ssce_pkg::ST_PIX;
                end else begin
                    n_state = ssce_pkg::ST_OUT;
                    n_p     = '0;
                end
            end
            ssce_pkg::ST_OUT: begin
                // write the finished pixel, then advance or report done
                if (r_out_rows != 7'd0 && r_out_cols != 7'd0) begin
                    o_we    = 32'(r_oi) < ssce_pkg::OUTPUT_DEPTH
                           && 32'(r_row) * 32'(r_out_cols) + 32'(r_col)
                              < ssce_pkg::OUTPUT_DEPTH;
                    o_wdata = (r_nz_cnt == '0) ? 16'd0 : r_acc;
                end
                if (r_out_rows != 7'd0 && r_out_cols != 7'd0 &&
                    !(last_col && r_row == r_out_rows - 7'd1)) begin
                    n_oi    = r_oi + 12'd1;
                    n_col   = last_col ? 7'd0 : r_col + 7'd1;
                    n_row   = last_col ? r_row + 7'd1 : r_row;
                    n_state = ssce_pkg::ST_PIX;
                end else if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_odata   = 16'd0;
                    n_odone   = 1'b1;
                    n_nz_cnt  = '0;
                    n_run_idx = 12'd0;
                    n_state   = ssce_pkg::ST_IDLE;
                end
            end
            default: n_state = ssce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssce_pkg::ST_CLEAR;
            r_run_idx <= 12'd0;
            r_nz_cnt  <= '0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_run_idx <= n_run_idx;
            r_nz_cnt  <= n_nz_cnt;
            r_clr     <= n_clr;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_row    <= n_row;
        r_col    <= n_col;
        r_oi     <= n_oi;
        r_rem    <= n_rem;
        r_lay    <= n_lay;
        r_dstep  <= n_dstep;
        r_base   <= n_base;
        r_y      <= n_y;
        r_x      <= n_x;
        r_flat   <= n_flat;
        r_tap_ok <= n_tap_ok;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_odata  <= n_odata;
        r_odone  <= n_odone;
        r_rd_ok  <= n_rd_ok;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_odone;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ssce_pkg::ST_IDLE)
        else $error("word accepted while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nz_cnt <= NZ_CW'(ssce_pkg::MAX_NONZEROS))
        else $error("nonzero count overflow");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssce_pkg::ST_OUT && n_state == ssce_pkg::ST_IDLE)
        |=> r_nz_cnt == '0 && r_run_idx == 12'd0)
        else $error("filter not consumed after compute");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the sparse strided convolution engine: stream stimulus, model-based checking.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [15:0] pix;
        logic        done;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic signed [15:0] in_mem [ssce_pkg::INPUT_DEPTH];
    bit                 in_written [ssce_pkg::INPUT_DEPTH];
    logic signed [15:0] w_mem [ssce_pkg::MAX_NONZEROS];
    logic [11:0]        w_idx [ssce_pkg::MAX_NONZEROS];
    logic signed [15:0] out_mem [ssce_pkg::OUTPUT_DEPTH];
    logic [11:0]        run_idx;
    int                 nz_cnt;
    int                 cfg [8];
    t_result            pending_q [$];
    int                 errors;
    int                 items;
    int                 hold_cycles;
    bit                 calm;

    sparse_strided_conv_engine dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic void conv_compute();
        int fr, fc, plane, oi, acc, prod, lay, fy, fx, y, x, idx;
        longint flat;
        fr = (cfg[ssce_pkg::REG_FILTER_ROWS] == 0) ? 1 : cfg[ssce_pkg::REG_FILTER_ROWS];
        fc = (cfg[ssce_pkg::REG_FILTER_COLS] == 0) ? 1 : cfg[ssce_pkg::REG_FILTER_COLS];
        plane = fr * fc;
        for (int r = 0; r < cfg[ssce_pkg::REG_OUT_ROWS]; r++) begin
            for (int c = 0; c < cfg[ssce_pkg::REG_OUT_COLS]; c++) begin
                oi = r * cfg[ssce_pkg::REG_OUT_COLS] + c;
                if (oi >= ssce_pkg::OUTPUT_DEPTH) continue;
                acc = 0;
                for (int p = 0; p < nz_cnt; p++) begin
                    idx = int'(w_idx[p]);
                    lay = idx / plane;
                    fy = (idx % plane) / fc;
                    fx = idx % fc;
                    y = r * cfg[ssce_pkg::REG_STRIDE_Y] + fy;
                    x = c * cfg[ssce_pkg::REG_STRIDE_X] + fx;
                    prod = 0;
                    if (y < cfg[ssce_pkg::REG_IN_ROWS] && x < cfg[ssce_pkg::REG_IN_COLS]) begin
                        flat = longint'(lay) * cfg[ssce_pkg::REG_IN_ROWS]
                               * cfg[ssce_pkg::REG_IN_COLS]
                             + longint'(y) * cfg[ssce_pkg::REG_IN_COLS] + x;
                        if (flat < ssce_pkg::INPUT_DEPTH)
                            prod = clip16((longint'(w_mem[p]) * longint'(in_mem[flat]))
                                          >>> ssce_pkg::FRAC_BITS);
                    end
                    acc = (p == 0) ? prod : clip16(longint'(acc) + prod);
                end
                out_mem[oi] = acc[15:0];
            end
        end
        nz_cnt = 0;
        run_idx = '0;
    endfunction

    function automatic void conv_step(ssce_pkg::t_opcode op, logic [13:0] a,
                                      logic signed [15:0] v, logic [11:0] off);
        t_result res;
        case (op)
            ssce_pkg::OP_LOAD: begin
                in_mem[a] = v;
                in_written[a] = 1'b1;
            end
            ssce_pkg::OP_APPEND: begin
                if (nz_cnt < ssce_pkg::MAX_NONZEROS) begin
                    run_idx = run_idx + off;
                    w_mem[nz_cnt] = v;
                    w_idx[nz_cnt] = run_idx;
                    nz_cnt++;
                end
            end
            ssce_pkg::OP_COMPUTE: begin
                conv_compute();
                res.pix = '0;
                res.done = 1'b1;
                pending_q.push_back(res);
            end
            default: begin
                res.pix = (a < ssce_pkg::OUTPUT_DEPTH) ? out_mem[a[11:0]] : 16'd0;
                res.done = 1'b0;
                pending_q.push_back(res);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 0);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata !== want.pix)
                    report_mismatch("result_value", m_axis_tdata, want.pix);
                if (m_axis_tuser !== want.done)
                    report_mismatch("done_res", m_axis_tuser, want.done);
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int idle_left;
        idle_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (idle_left > 0) begin
                m_axis_tready <= 1'b0;
                idle_left--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                idle_left = $urandom_range(0, 12);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(ssce_pkg::t_opcode op, logic [13:0] a, logic [15:0] v,
                             logic [11:0] off, bit gaps = 1);
        if (op == ssce_pkg::OP_COMPUTE) fill_taps();
        if (gaps && !calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, off, v, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        conv_step(op, a, v, off);
        items++;
    endtask

    // load every input entry that the coming compute taps and that was never written
    task automatic fill_taps();
        int fr, fc, plane, oi, idx, lay, y, x;
        longint flat;
        fr = (cfg[ssce_pkg::REG_FILTER_ROWS] == 0) ? 1 : cfg[ssce_pkg::REG_FILTER_ROWS];
        fc = (cfg[ssce_pkg::REG_FILTER_COLS] == 0) ? 1 : cfg[ssce_pkg::REG_FILTER_COLS];
        plane = fr * fc;
        for (int r = 0; r < cfg[ssce_pkg::REG_OUT_ROWS]; r++) begin
            for (int c = 0; c < cfg[ssce_pkg::REG_OUT_COLS]; c++) begin
                oi = r * cfg[ssce_pkg::REG_OUT_COLS] + c;
                if (oi >= ssce_pkg::OUTPUT_DEPTH) continue;
                for (int p = 0; p < nz_cnt; p++) begin
                    idx = int'(w_idx[p]);
                    lay = idx / plane;
                    y = r * cfg[ssce_pkg::REG_STRIDE_Y] + (idx % plane) / fc;
                    x = c * cfg[ssce_pkg::REG_STRIDE_X] + idx % fc;
                    if (y < cfg[ssce_pkg::REG_IN_ROWS] && x < cfg[ssce_pkg::REG_IN_COLS]) begin
                        flat = longint'(lay) * cfg[ssce_pkg::REG_IN_ROWS]
                               * cfg[ssce_pkg::REG_IN_COLS]
                             + longint'(y) * cfg[ssce_pkg::REG_IN_COLS] + x;
                        if (flat < ssce_pkg::INPUT_DEPTH && !in_written[flat])
                            send_word(ssce_pkg::OP_LOAD, 14'(flat), pick16(),
                                      12'($urandom), 0);
                    end
                end
            end
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(ssce_pkg::t_reg_index r, int val);
        int mask;
        case (r)
            ssce_pkg::REG_OUT_ROWS, ssce_pkg::REG_OUT_COLS: mask = 'h7f;
            ssce_pkg::REG_IN_ROWS, ssce_pkg::REG_IN_COLS: mask = 'hff;
            default: mask = 'hf;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg[r] = val & mask;
    endtask

    task automatic set_shape(int sy, int sx, int orows, int ocols, int irows, int icols,
                             int frows, int fcols);
        wait_drain();
        write_reg(ssce_pkg::REG_STRIDE_Y, sy);
        write_reg(ssce_pkg::REG_STRIDE_X, sx);
        write_reg(ssce_pkg::REG_OUT_ROWS, orows);
        write_reg(ssce_pkg::REG_OUT_COLS, ocols);
        write_reg(ssce_pkg::REG_IN_ROWS, irows);
        write_reg(ssce_pkg::REG_IN_COLS, icols);
        write_reg(ssce_pkg::REG_FILTER_ROWS, frows);
        write_reg(ssce_pkg::REG_FILTER_COLS, fcols);
    endtask

    task automatic read_pixels(int n);
        for (int i = 0; i < n; i++)
            send_word(ssce_pkg::OP_READ, 14'(i), pick16(), 12'($urandom));
    endtask

    task automatic test_directed();
        set_shape(1, 1, 2, 2, 8, 8, 3, 3);
        send_word(ssce_pkg::OP_LOAD, 14'd0, 16'h7fff, 12'hfff);
        send_word(ssce_pkg::OP_LOAD, 14'h3fff, 16'h8000, 12'h000);
        send_word(ssce_pkg::OP_APPEND, 14'h3fff, 16'h7fff, 12'd0);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'h8000, 12'hfff);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'h7fff, 12'd5);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'h0001, 12'd1);
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        read_pixels(4);
        send_word(ssce_pkg::OP_READ, 14'h3fff, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd4095, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        read_pixels(2);
        set_shape(0, 0, 3, 3, 255, 255, 0, 0);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'h4000, 12'd3);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'hc000, 12'd7);
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        read_pixels(4);
    endtask

    task automatic test_filter_full();
        set_shape(15, 15, 1, 1, 4, 4, 15, 15);
        for (int i = 0; i < ssce_pkg::MAX_NONZEROS + 3; i++)
            send_word(ssce_pkg::OP_APPEND, 14'($urandom), pick16(),
                      12'($urandom_range(0, 60)));
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        read_pixels(1);
    endtask

    task automatic test_large_output();
        set_shape(1, 1, 127, 127, 1, 1, 1, 1);
        send_word(ssce_pkg::OP_APPEND, 14'd0, 16'h7fff, 12'd0);
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd4095, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd4096, 16'd0, 12'd0);
        set_shape(2, 3, 64, 64, 8, 8, 2, 2);
        send_word(ssce_pkg::OP_APPEND, 14'd0, pick16(), 12'd1);
        send_word(ssce_pkg::OP_APPEND, 14'd0, pick16(), 12'd4);
        send_word(ssce_pkg::OP_COMPUTE, 14'd0, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd4095, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd1234, 16'd0, 12'd0);
        send_word(ssce_pkg::OP_READ, 14'd65, 16'd0, 12'd0);
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_word(ssce_pkg::OP_READ, 14'($urandom_range(0, 4200)), 16'd0, 12'd0);
        wait_drain();
    endtask

    task automatic test_random();
        int n, span;
        while (items < 590) begin
            if (items > 500) calm = 1'b1;
            set_shape($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 8),
                      $urandom_range(0, 8), $urandom_range(0, 10), $urandom_range(0, 10),
                      $urandom_range(0, 15), $urandom_range(0, 15));
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
                send_word(ssce_pkg::OP_APPEND, 14'($urandom), pick16(),
                          ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 20)) :
                                                         12'($urandom));
                if ($urandom_range(0, 3) == 0)
                    send_word(ssce_pkg::OP_LOAD, 14'($urandom), pick16(), 12'($urandom));
            end
            if ($urandom_range(0, 4) == 0)
                send_word(ssce_pkg::t_opcode'($urandom_range(0, 3)), 14'($urandom), pick16(),
                          12'($urandom));
            send_word(ssce_pkg::OP_COMPUTE, 14'($urandom), pick16(), 12'($urandom));
            span = cfg[ssce_pkg::REG_OUT_ROWS] * cfg[ssce_pkg::REG_OUT_COLS] + 1;
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_word(ssce_pkg::OP_READ, ($urandom_range(0, 5) == 0) ? 14'($urandom) :
                                   14'($urandom_range(0, span)), pick16(), 12'($urandom));
        end
    endtask

    initial begin
        #(30_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        errors = 0;
        items = 0;
        hold_cycles = 0;
        calm = 1'b0;
        nz_cnt = 0;
        run_idx = '0;
        for (int i = 0; i < ssce_pkg::OUTPUT_DEPTH; i++) out_mem[i] = '0;
        for (int i = 0; i < 8; i++) cfg[i] = 1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        test_directed();
        test_filter_full();
        test_large_output();
        test_backpressure();
        test_random();
        wait_drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssce_pkg.sv
rtl/ssce_ram.sv
rtl/sparse_strided_conv_engine.sv
verif/tb_top.sv
